// ===== rtl/core/grpc_pkg.sv =====
package grpc_pkg;

    // fixed field widths of the ports and configuration registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int POSE_IN_W  = 11;
    localparam int ATOM_IN_W  = 9;
    localparam int COORD_IN_W = 16;
    localparam int CLUS_OUT_W = 12;
    localparam int CUTOFF_W   = 16;
    localparam int PCOUNT_W   = 12;
    localparam int ACOUNT_W   = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULTI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PCOUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACOUNT  = 3'd4;

    localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 16'd1024;
    localparam logic [ACOUNT_W-1:0] ACOUNT_RST = 10'd1;

    // item kinds
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CLR  = 13'b0000000000010,
        S_CSQ  = 13'b0000000000100,
        S_THR  = 13'b0000000001000,
        S_SCAN = 13'b0000000010000,
        S_SLBL = 13'b0000000100000,
        S_DINIT= 13'b0000001000000,
        S_RD   = 13'b0000010000000,
        S_SQ   = 13'b0000100000000,
        S_FIN  = 13'b0001000000000,
        S_CMP  = 13'b0010000000000,
        S_LEAD = 13'b0100000000000,
        S_LLBL = 13'b1000000000000
    } t_state;

endpackage

// ===== rtl/core/grpc_store.sv =====
module grpc_store #(
    parameter int ADDR_W = 21,
    parameter int WORD_W = 48
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WORD_W-1:0] o_rdata_a,
    output logic [WORD_W-1:0] o_rdata_b
);

    // packed {z, y, x} per atom and side
    logic [WORD_W-1:0] r_mem [2**ADDR_W];
    logic [WORD_W-1:0] r_rda;
    logic [WORD_W-1:0] r_rdb;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rda <= r_mem[i_raddr_a];
            r_rdb <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rda;
    assign o_rdata_b = r_rdb;

endmodule

// ===== rtl/core/greedy_rmsd_pose_clustering.sv =====
// Greedy leader clustering of docking poses by RMSD. Coordinate stores may
// follow back to back; they yield no result. A fetch raises busy and returns
// exactly one row on o_strobe, for one cycle, when busy falls; the receiver
// cannot stall it, so capture every strobe. A fetch works out the threshold,
// tries poses as leaders, reads the label of each candidate pose and, per
// side compared, streams the atoms through the single shared squarer (one
// coordinate per cycle, one pose memory read per atom). The first fetch after
// a coordinate write that follows a run, and the first fetch after reset,
// first sweeps the label memory.
module greedy_rmsd_pose_clustering #(
    parameter int MAX_POSES  = 2048,
    parameter int MAX_ATOMS  = 512,
    parameter int COORD_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_cfg_we,
    input  logic [grpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [grpc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 i_kind,
    input  logic [grpc_pkg::POSE_IN_W-1:0]       i_pose_index,
    input  logic                                 i_side,
    input  logic [grpc_pkg::ATOM_IN_W-1:0]       i_atom_index,
    input  logic signed [grpc_pkg::COORD_IN_W-1:0] i_coord_x,
    input  logic signed [grpc_pkg::COORD_IN_W-1:0] i_coord_y,
    input  logic signed [grpc_pkg::COORD_IN_W-1:0] i_coord_z,
    output logic                                 o_strobe,
    output logic [grpc_pkg::POSE_IN_W-1:0]       o_out_pose,
    output logic [grpc_pkg::CLUS_OUT_W-1:0]      o_cluster_number,
    output logic                                 o_is_leader,
    output logic                                 o_done_res
);

    import grpc_pkg::*;

    localparam int PB     = $clog2(MAX_POSES);
    localparam int PW     = $clog2(MAX_POSES + 1);
    localparam int AB     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int AW     = $clog2(MAX_ATOMS + 1);
    localparam int CB     = COORD_BITS;
    localparam int MW     = CB + 1;
    localparam int ADDR_W = PB + 1 + AB;
    localparam int WORD_W = 3 * CB;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // configuration
    logic [CUTOFF_W-1:0] r_cutoff;
    logic                r_multi;
    logic                r_report;
    logic [PCOUNT_W-1:0] r_pcount;
    logic [ACOUNT_W-1:0] r_acount;

    // sequencer and run state
    t_state           r_state, n_state;
    logic [PW-1:0]    r_leader, n_leader;
    logic [PW-1:0]    r_scan, n_scan;
    logic [PW-1:0]    r_total, n_total;
    logic [PW-1:0]    r_clr_cnt, n_clr_cnt;
    logic             r_clr_pend, n_clr_pend;
    logic             r_lbl_dirty, n_lbl_dirty;
    logic [PB-1:0]    r_j, n_j;
    logic             r_side, n_side;
    logic [AW-1:0]    r_k, n_k;
    logic [1:0]       r_c, n_c;
    logic [31:0]      r_csq, n_csq;
    logic [63:0]      r_thr, n_thr;
    logic [63:0]      r_sum, n_sum;
    logic [63:0]      r_sq, n_sq;
    logic             r_sq_vld, n_sq_vld;

    // result register
    logic                  r_ovld, n_ovld;
    logic [POSE_IN_W-1:0]  r_opose, n_opose;
    logic [CLUS_OUT_W-1:0] r_onum, n_onum;
    logic                  r_olead, n_olead;
    logic                  r_odone, n_odone;

    // label flags, one bit per pose: set once labeled in this run
    logic             r_lbl_mem [MAX_POSES];
    logic             r_lbl_q;
    logic             w_lbl_we;
    logic [PB-1:0]    w_lbl_waddr;
    logic             w_lbl_wdata;
    logic [PB-1:0]    w_lbl_raddr;

    // pose memory ports
    logic              w_pwe;
    logic [ADDR_W-1:0] w_pwaddr;
    logic [WORD_W-1:0] w_pwdata;
    logic              w_pre;
    logic [ADDR_W-1:0] w_praddr_a;
    logic [ADDR_W-1:0] w_praddr_b;
    logic [WORD_W-1:0] w_prdata_a;
    logic [WORD_W-1:0] w_prdata_b;

    logic              w_acc;
    logic              w_st_ok;
    logic [PW-1:0]     w_np;
    logic [AW-1:0]     w_na;
    logic [31+AW:0]    w_thr_prod;
    logic [CB-1:0]     w_ca;
    logic [CB-1:0]     w_cb;
    logic signed [MW-1:0] w_diff;
    logic [MW-1:0]     w_mag;
    logic [2*MW-1:0]   w_prod;
    logic [63:0]       w_sq;

    assign w_acc   = start && !busy;
    assign w_st_ok = (32'(i_pose_index) < MAX_POSES) && (32'(i_atom_index) < MAX_ATOMS);

    // counts above the capacity are clipped
    assign w_np = (32'(r_pcount) > MAX_POSES) ? PW'(MAX_POSES) : PW'(r_pcount);
    assign w_na = (32'(r_acount) > MAX_ATOMS) ? AW'(MAX_ATOMS) : AW'(r_acount);

    assign w_thr_prod = r_csq * w_na;

    // store write path: coordinates keep the low COORD_BITS bits
    assign w_pwe    = w_acc && (i_kind == KIND_STORE) && w_st_ok;
    assign w_pwaddr = {PB'(i_pose_index), i_side, AB'(i_atom_index)};
    assign w_pwdata = {CB'($unsigned(i_coord_z)), CB'($unsigned(i_coord_y)),
                       CB'($unsigned(i_coord_x))};

    // leader side 0 against candidate side r_side, atom r_k
    assign w_praddr_a = {r_leader[PB-1:0], 1'b0, r_k[AB-1:0]};
    assign w_praddr_b = {r_j, r_side, r_k[AB-1:0]};

    // shared squarer: one coordinate per cycle
    assign w_ca   = w_prdata_a[r_c*CB +: CB];
    assign w_cb   = w_prdata_b[r_c*CB +: CB];
    assign w_diff = $signed({w_ca[CB-1], w_ca}) - $signed({w_cb[CB-1], w_cb});
    assign w_mag  = w_diff[MW-1] ? MW'(-w_diff) : MW'(w_diff);
    assign w_prod = w_mag * w_mag;
    assign w_sq   = (64'(w_mag) > 64'hFFFF_FFFF) ? '1 : 64'(w_prod);

    assign w_lbl_raddr = (r_state == S_LEAD) ? r_leader[PB-1:0] : r_scan[PB-1:0];

    always_comb begin
        n_state     = r_state;
        n_leader    = r_leader;
        n_scan      = r_scan;
        n_total     = r_total;
        n_clr_cnt   = r_clr_cnt;
        n_clr_pend  = r_clr_pend;
        n_lbl_dirty = r_lbl_dirty;
        n_j         = r_j;
        n_side      = r_side;
        n_k         = r_k;
        n_c         = r_c;
        n_csq       = r_csq;
        n_thr       = r_thr;
        n_sq        = r_sq;
        n_sq_vld    = 1'b0;
        n_ovld      = 1'b0;
        n_opose     = r_opose;
        n_onum      = r_onum;
        n_olead     = r_olead;
        n_odone     = r_odone;
        w_lbl_we    = 1'b0;
        w_lbl_waddr = r_j;
        w_lbl_wdata = 1'b1;
        w_pre       = 1'b0;
        // accumulate the square from the cycle before
        n_sum       = r_sq_vld ? sat_add(r_sum, r_sq) : r_sum;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_kind == KIND_STORE) begin
                        if (w_st_ok) begin
                            n_leader   = '0;
                            n_scan     = '0;
                            n_total    = '0;
                            n_clr_pend = 1'b1;
                        end
                    end else begin
                        n_clr_pend = 1'b0;
                        n_clr_cnt  = '0;
                        n_state    = (r_clr_pend && r_lbl_dirty) ? S_CLR : S_CSQ;
                    end
                end
            end
            S_CLR: begin
                // label sweep, one entry a cycle
                w_lbl_we    = 1'b1;
                w_lbl_waddr = r_clr_cnt[PB-1:0];
                w_lbl_wdata = 1'b0;
                if (r_clr_cnt == PW'(MAX_POSES - 1)) begin
                    n_lbl_dirty = 1'b0;
                    n_state     = S_CSQ;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            S_CSQ: begin
                n_csq   = r_cutoff * r_cutoff;
                n_state = S_THR;
            end
            S_THR: begin
                n_thr   = 64'(w_thr_prod);
                n_state = (r_scan != '0) ? S_SCAN : S_LEAD;
            end
            S_SCAN: begin
                if (r_scan < w_np) begin
                    n_j     = r_scan[PB-1:0];
                    n_scan  = r_scan + 1'b1;
                    n_state = S_SLBL;
                end else begin
                    // open cluster exhausted
                    n_scan   = '0;
                    n_leader = r_leader + 1'b1;
                    n_state  = S_LEAD;
                end
            end
            S_SLBL: begin
                if (!r_lbl_q && (r_leader < w_np)) begin
                    n_side  = 1'b0;
                    n_state = S_DINIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DINIT: begin
                n_sum   = '0;
                n_k     = '0;
                n_state = (w_na == '0) ? S_CMP : S_RD;
            end
            S_RD: begin
                w_pre   = 1'b1;
                n_k     = r_k + 1'b1;
                n_c     = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                n_sq     = w_sq;
                n_sq_vld = 1'b1;
                if (r_c == 2'd2) begin
                    n_state = (r_k == w_na) ? S_FIN : S_RD;
                end else begin
                    n_c = r_c + 1'b1;
                end
            end
            S_FIN: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_sum < r_thr) begin
                    // candidate joins the open cluster
                    w_lbl_we    = 1'b1;
                    w_lbl_waddr = r_j;
                    n_lbl_dirty = 1'b1;
                    if (r_report) begin
                        n_ovld  = 1'b1;
                        n_opose = POSE_IN_W'(r_j);
                        n_onum  = CLUS_OUT_W'(r_total);
                        n_olead = 1'b0;
                        n_odone = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (r_multi && !r_side) begin
                    n_side  = 1'b1;
                    n_state = S_DINIT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_LEAD: begin
                if (r_leader < w_np) begin
                    n_state = S_LLBL;
                end else begin
                    // done row, repeats on later fetches
                    n_ovld  = 1'b1;
                    n_opose = '0;
                    n_onum  = CLUS_OUT_W'(r_total);
                    n_olead = 1'b0;
                    n_odone = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LLBL: begin
                if (!r_lbl_q) begin
                    // unlabeled pose founds a cluster
                    w_lbl_we    = 1'b1;
                    w_lbl_waddr = r_leader[PB-1:0];
                    n_lbl_dirty = 1'b1;
                    n_total     = r_total + 1'b1;
                    n_scan      = r_leader + 1'b1;
                    n_ovld      = 1'b1;
                    n_opose     = POSE_IN_W'(r_leader);
                    n_onum      = CLUS_OUT_W'(r_total + 1'b1);
                    n_olead     = 1'b1;
                    n_odone     = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    n_leader = r_leader + 1'b1;
                    n_state  = S_LEAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_leader    <= '0;
            r_scan      <= '0;
            r_total     <= '0;
            r_clr_cnt   <= '0;
            r_clr_pend  <= 1'b1;
            r_lbl_dirty <= 1'b1;
            r_sq_vld    <= 1'b0;
            r_ovld      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_leader    <= n_leader;
            r_scan      <= n_scan;
            r_total     <= n_total;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_pend  <= n_clr_pend;
            r_lbl_dirty <= n_lbl_dirty;
            r_sq_vld    <= n_sq_vld;
            r_ovld      <= n_ovld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_side  <= n_side;
        r_k     <= n_k;
        r_c     <= n_c;
        r_csq   <= n_csq;
        r_thr   <= n_thr;
        r_sum   <= n_sum;
        r_sq    <= n_sq;
        r_opose <= n_opose;
        r_onum  <= n_onum;
        r_olead <= n_olead;
        r_odone <= n_odone;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= CUTOFF_RST;
            r_multi  <= 1'b0;
            r_report <= 1'b0;
            r_pcount <= '0;
            r_acount <= ACOUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CUTOFF: r_cutoff <= i_cfg_wdata[CUTOFF_W-1:0];
                REG_MULTI:  r_multi  <= i_cfg_wdata[0];
                REG_REPORT: r_report <= i_cfg_wdata[0];
                REG_PCOUNT: r_pcount <= i_cfg_wdata[PCOUNT_W-1:0];
                REG_ACOUNT: r_acount <= i_cfg_wdata[ACOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // label memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_lbl_we) begin
            r_lbl_mem[w_lbl_waddr] <= w_lbl_wdata;
        end
        r_lbl_q <= r_lbl_mem[w_lbl_raddr];
    end

    grpc_store #(
        .ADDR_W (ADDR_W),
        .WORD_W (WORD_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_pwe),
        .i_waddr   (w_pwaddr),
        .i_wdata   (w_pwdata),
        .i_re      (w_pre),
        .i_raddr_a (w_praddr_a),
        .i_raddr_b (w_praddr_b),
        .o_rdata_a (w_prdata_a),
        .o_rdata_b (w_prdata_b)
    );

    assign busy             = (r_state != S_IDLE);
    assign o_strobe         = r_ovld;
    assign o_out_pose       = r_opose;
    assign o_cluster_number = r_onum;
    assign o_is_leader      = r_olead;
    assign o_done_res       = r_odone;

    // a result transfer only ends a fetch
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> ($past(r_state) != S_IDLE))
        else $error("result strobe without a fetch in progress");

    // an accepted fetch always raises busy
    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_FETCH)) |=> busy)
        else $error("fetch accepted but block not busy");

    // an open cluster scans only past its leader
    a_scan_past_leader: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan != '0) |-> (r_scan > r_leader))
        else $error("scan position not beyond leader");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import grpc_pkg::*;

    localparam int NPOSE = 2048;
    localparam int NATOM = 512;

    // one result row as seen on the output ports
    typedef struct packed {
        logic [POSE_IN_W-1:0]  pose;
        logic [CLUS_OUT_W-1:0] num;
        logic                  lead;
        logic                  done;
    } t_row;

    // in-order store of expected rows, checked against every strobe
    class cluster_scoreboard;
        t_row pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function void note(t_row r);
            pending.insert(pending.size(), r);
        endfunction

        function void check(t_row got);
            t_row want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected row pose=%0d num=%0d lead=%0d done=%0d",
                         $time, got.pose, got.num, got.lead, got.done);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.pose !== want.pose) begin
                $display("%0t: out_pose expected %0d actual %0d", $time, want.pose, got.pose);
                errors++;
            end
            if (got.num !== want.num) begin
                $display("%0t: cluster_number expected %0d actual %0d",
                         $time, want.num, got.num);
                errors++;
            end
            if (got.lead !== want.lead) begin
                $display("%0t: is_leader expected %0d actual %0d", $time, want.lead, got.lead);
                errors++;
            end
            if (got.done !== want.done) begin
                $display("%0t: done_res expected %0d actual %0d", $time, want.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   i_kind;
    logic [POSE_IN_W-1:0]   i_pose_index;
    logic                   i_side;
    logic [ATOM_IN_W-1:0]   i_atom_index;
    logic signed [COORD_IN_W-1:0] i_coord_x;
    logic signed [COORD_IN_W-1:0] i_coord_y;
    logic signed [COORD_IN_W-1:0] i_coord_z;
    logic                   o_strobe;
    logic [POSE_IN_W-1:0]   o_out_pose;
    logic [CLUS_OUT_W-1:0]  o_cluster_number;
    logic                   o_is_leader;
    logic                   o_done_res;

    greedy_rmsd_pose_clustering u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_kind           (i_kind),
        .i_pose_index     (i_pose_index),
        .i_side           (i_side),
        .i_atom_index     (i_atom_index),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .o_strobe         (o_strobe),
        .o_out_pose       (o_out_pose),
        .o_cluster_number (o_cluster_number),
        .o_is_leader      (o_is_leader),
        .o_done_res       (o_done_res)
    );

    cluster_scoreboard sb = new();

    // predictor copy of the block state
    int          coord_mem[longint];
    int unsigned label_of[NPOSE];
    int unsigned leader_pos;
    int unsigned scan_pos;
    int unsigned clusters;
    int unsigned cut_reg;
    int unsigned multi_reg;
    int unsigned report_reg;
    int unsigned pcount_reg;
    int unsigned acount_reg;
    bit          done_seen;

    // sender pacing
    int burst_left;
    int accepted;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // results cannot be held off, so every strobe is checked at its edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check({o_out_pose, o_cluster_number, o_is_leader, o_done_res});
        end
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic longint slot_of(int pose, int side, int atom);
        return ((longint'(pose) * 2 + side) * NATOM + atom) * 3;
    endfunction

    function automatic int unsigned atoms_used();
        return (acount_reg > NATOM) ? NATOM : acount_reg;
    endfunction

    function automatic int unsigned poses_used();
        return (pcount_reg > NPOSE) ? NPOSE : pcount_reg;
    endfunction

    // saturating sum of squared coordinate differences, leader side 0
    function automatic longint unsigned dist_sq(int a, int b, int bside);
        longint unsigned sum;
        longint unsigned sq;
        longint          d;
        sum = 0;
        for (int k = 0; k < atoms_used(); k++) begin
            for (int c = 0; c < 3; c++) begin
                d  = longint'(coord_mem[slot_of(a, 0, k) + c])
                   - longint'(coord_mem[slot_of(b, bside, k) + c]);
                if (d < 0) d = -d;
                sq = longint'(d) * longint'(d);
                sum = (sum + sq < sum) ? '1 : sum + sq;
            end
        end
        return sum;
    endfunction

    function automatic bit near_leader(int a, int b);
        longint unsigned thr;
        thr = longint'(cut_reg) * cut_reg * atoms_used();
        if (dist_sq(a, b, 0) < thr) return 1'b1;
        return multi_reg != 0 && dist_sq(a, b, 1) < thr;
    endfunction

    function automatic void clear_labels();
        foreach (label_of[i]) label_of[i] = 0;
        leader_pos = 0;
        scan_pos   = 0;
        clusters   = 0;
        done_seen  = 1'b0;
    endfunction

    function automatic t_row make_row(int pose, int num, bit lead, bit dn);
        t_row r;
        r.pose = pose[POSE_IN_W-1:0];
        r.num  = num[CLUS_OUT_W-1:0];
        r.lead = lead;
        r.done = dn;
        return r;
    endfunction

    // next row of the greedy leader scan
    function automatic t_row next_cluster_row();
        int unsigned n;
        int unsigned j;
        n = poses_used();
        // finish the open cluster first
        if (scan_pos != 0) begin
            while (scan_pos < n) begin
                j = scan_pos;
                scan_pos++;
                if (label_of[j] == 0 && leader_pos < n && near_leader(leader_pos, j)) begin
                    label_of[j] = clusters;
                    if (report_reg != 0) return make_row(j, clusters, 1'b0, 1'b0);
                end
            end
            scan_pos = 0;
            leader_pos++;
        end
        // then look for the next unlabeled pose
        while (leader_pos < n) begin
            if (label_of[leader_pos] == 0) begin
                clusters++;
                label_of[leader_pos] = clusters;
                scan_pos = leader_pos + 1;
                return make_row(leader_pos, clusters, 1'b1, 1'b0);
            end
            leader_pos++;
        end
        done_seen = 1'b1;
        return make_row(0, clusters, 1'b0, 1'b1);
    endfunction

    // one item: hold start until a transfer, then update the predictor
    task automatic send_item(logic kind, int pose, int side, int atom,
                             logic [15:0] x, logic [15:0] y, logic [15:0] z);
        logic was_busy;
        longint p;
        @(negedge i_clk);
        start        <= 1'b1;
        i_kind       <= kind;
        i_pose_index <= pose[POSE_IN_W-1:0];
        i_side       <= side[0];
        i_atom_index <= atom[ATOM_IN_W-1:0];
        i_coord_x    <= x;
        i_coord_y    <= y;
        i_coord_z    <= z;
        forever begin
            #0 was_busy = busy;
            @(posedge i_clk);
            if (!was_busy) break;
            @(negedge i_clk);
        end
        accepted++;
        if (kind == KIND_STORE) begin
            p = slot_of(pose[POSE_IN_W-1:0], side[0], atom[ATOM_IN_W-1:0]);
            coord_mem[p]     = int'(signed'(x));
            coord_mem[p + 1] = int'(signed'(y));
            coord_mem[p + 2] = int'(signed'(z));
            clear_labels();
        end else begin
            sb.note(next_cluster_row());
        end
        // bursts with random gaps; a zero gap keeps start high
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 12);
            repeat ($urandom_range(0, 6)) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
    endtask

    task automatic fetch_row();
        send_item(KIND_FETCH, $urandom_range(0, 2047), $urandom_range(0, 1),
                  $urandom_range(0, 511), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // lower start and wait until every expected row has come
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_CUTOFF: cut_reg    = val & 16'hFFFF;
            REG_MULTI:  multi_reg  = val & 1;
            REG_REPORT: report_reg = val & 1;
            REG_PCOUNT: pcount_reg = val & 12'hFFF;
            REG_ACOUNT: acount_reg = val & 10'h3FF;
            default: ;
        endcase
    endtask

    // one clustering run: settings, coordinate load, then fetch to the end
    task automatic run_phase(int unsigned pc, int unsigned ac, int unsigned cut,
                             int unsigned multi, int unsigned rep, int spread);
        logic [15:0] center[3][3];
        int          grp;
        int          sides;
        int          nfetch;
        int          extra;
        int          pressure_at;
        drain();
        repeat (20) @(negedge i_clk);
        write_reg(REG_CUTOFF, cut);
        write_reg(REG_MULTI, multi);
        write_reg(REG_REPORT, rep);
        write_reg(REG_PCOUNT, pc);
        write_reg(REG_ACOUNT, ac);
        foreach (center[g, c]) center[g][c] = 16'($urandom);
        sides = (multi != 0) ? 2 : 1;
        // every entry the scan reads is written before the first fetch
        for (int p = 0; p < poses_used(); p++) begin
            for (int s = 0; s < sides; s++) begin
                grp = $urandom_range(0, 2);
                for (int a = 0; a < atoms_used(); a++) begin
                    send_item(KIND_STORE, p, s, a,
                              16'(center[grp][0] + $urandom_range(0, 2 * spread) - spread),
                              16'(center[grp][1] + $urandom_range(0, 2 * spread) - spread),
                              16'(center[grp][2] + $urandom_range(0, 2 * spread) - spread));
                end
            end
        end
        nfetch      = 0;
        extra       = $urandom_range(1, 3);
        pressure_at = $urandom_range(1, 6);
        while (!(done_seen && extra == 0) && nfetch < 3 * NPOSE + 16) begin
            // occasional stray store restarts the run
            if ($urandom_range(0, 30) == 0) begin
                send_item(KIND_STORE, $urandom_range(0, 2047), $urandom_range(0, 1),
                          $urandom_range(0, 511), 16'($urandom), 16'($urandom),
                          16'($urandom));
            end else begin
                fetch_row();
                nfetch++;
                if (done_seen) extra--;
            end
            if (nfetch == pressure_at) drain();
        end
    endtask

    initial begin
        int unsigned spr;
        int unsigned cut;
        start        = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        i_kind       = KIND_STORE;
        i_pose_index = '0;
        i_side       = 1'b0;
        i_atom_index = '0;
        i_coord_x    = '0;
        i_coord_y    = '0;
        i_coord_z    = '0;
        i_rst_n      = 1'b0;
        burst_left   = 0;
        accepted     = 0;
        cut_reg      = CUTOFF_RST;
        multi_reg    = 0;
        report_reg   = 0;
        pcount_reg   = 0;
        acount_reg   = ACOUNT_RST;
        clear_labels();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: no poses, so fetches give the done row
        fetch_row();
        fetch_row();

        // directed corners
        run_phase(0, 1, 1024, 0, 1, 4);
        run_phase(3, 0, 65535, 1, 1, 4);          // zero atoms, nobody joins
        run_phase(5, 2, 0, 1, 1, 4);              // zero cutoff
        run_phase(48, 1, 65535, 0, 0, 100);       // one big cluster
        run_phase(2, 1023, 65535, 0, 1, 0);       // atom count clamped
        run_phase(6, 1, 65535, 1, 1, 0);          // identical poses all join

        // random runs with small sizes
        while (accepted < 1650) begin
            case ($urandom_range(0, 3))
                0: spr = 0;
                1: spr = 4;
                2: spr = 64;
                default: spr = 2000;
            endcase
            case ($urandom_range(0, 5))
                0: cut = 0;
                1: cut = 65535;
                default: cut = $urandom_range(0, 4 * spr + 8);
            endcase
            run_phase($urandom_range(1, 8), $urandom_range(0, 3), cut,
                      $urandom_range(0, 1), $urandom_range(0, 1), spr);
        end

        drain();
        repeat (50) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
